FILE: design/bitmap_first_free_allocator_defines.svh
// Assertion helpers for the allocator checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bffa check failed");

// Next-cycle implication, checked outside reset.
`define BFFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bffa check failed");

`endif

FILE: design/bffa_pkg.sv
package bffa_pkg;

  localparam int MAP_BITS  = 8192;
  localparam int WORD_BITS = 32;
  localparam int WORDS     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = $clog2(WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BITNUM_W  = $clog2(MAP_BITS);
  localparam int CNT_W     = 14;
  localparam int HI_W      = CNT_W - BIT_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_FORMAT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT     = 2'd0,
    CFG_INODE_COUNT     = 2'd1,
    CFG_RESERVED_BLOCKS = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ALLOC_WR,
    S_FREE_RD,
    S_FREE_WR,
    S_FORMAT,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;     // capture request fields
    logic    addr_clr;  // rewind word counter
    logic    scan;      // first-free search, one word per cycle
    logic    alloc_wr;  // write back found word with bit set
    logic    free_rd;   // read word holding the bit to free
    logic    free_wr;   // write back word with bit cleared
    logic    sweep;     // write every word of both maps
    logic    clear;     // sweep writes zeros (post-reset pass)
    logic    respond;   // load result registers
    status_t status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       idx_bad;
    logic       found;
    logic       last_word;
    logic       sweep_last;
  } sts_t;

endpackage

FILE: design/bitmap_first_free_allocator.sv
// First-fit allocator over two bitmaps (data blocks, inodes), 256 words of
// 32 bits each, with a free counter per pool. Pulse start while busy is low
// to issue a request; it is taken at that edge. Exactly one result follows,
// shown for a single cycle with out_valid high; there is no way to hold it
// off, so sample it when it appears. Steps per request: allocate decodes,
// then searches the bitmap words until a free bit turns up (at most 256
// words) and writes the found word back with that bit set; the search
// reads one word per cycle through the bitmap RAM port; a search that
// finds nothing answers with no space; a free request reads, modifies and
// writes back its word; format sweeps all 256 words of both maps, one per
// cycle; a refused request (no free count, number out of range) or an
// unused func code answers straight after decode.
// After reset the block runs a clearing pass over both maps and
// holds busy high meanwhile. The next request may be issued in the cycle
// the result is shown. Configuration writes (cfg_we) take effect at once
// and are meant only while busy is low; counts above 8192 act as 8192.
module bitmap_first_free_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic                           in_pool,
  input  logic [bffa_pkg::CNT_W-1:0]     in_index,
  // result channel
  output logic                           out_valid,
  output logic [bffa_pkg::CNT_W-1:0]     out_number,
  output logic [1:0]                     out_status,
  output logic [bffa_pkg::CNT_W-1:0]     out_free_left,
  // configuration
  input  logic                           cfg_we,
  input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bffa_pkg::CNT_W-1:0]     cfg_wdata
);
  import bffa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decodes the request, steps search / read-modify-write / sweep.
  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Bitmaps, counters, config registers and the result register.
  bffa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_pool       (in_pool),
    .in_index      (in_index),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_number    (out_number),
    .out_status    (out_status),
    .out_free_left (out_free_left)
  );

endmodule

FILE: design/bffa_ram.sv
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/bffa_ctrl.sv
module bffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  bffa_pkg::sts_t  sts,
  output bffa_pkg::cmd_t  cmd,
  output logic            busy
);
  import bffa_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        st_nxt = ST_OK;
        unique case (sts.func)
          FN_ALLOC: begin
            if (sts.cnt_zero) begin
              st_nxt    = ST_NO_SPACE;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          FN_FREE: begin
            if (sts.idx_bad) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_FREE_RD;
            end
          end
          FN_FORMAT: state_nxt = S_FORMAT;
          default:   state_nxt = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (sts.found) begin
          state_nxt = S_ALLOC_WR;
        end else if (sts.last_word) begin
          st_nxt    = ST_NO_SPACE;
          state_nxt = S_RESP;
        end
      end
      S_ALLOC_WR: state_nxt = S_RESP;
      S_FREE_RD:  state_nxt = S_FREE_WR;
      S_FREE_WR:  state_nxt = S_RESP;
      S_FORMAT: begin
        if (sts.sweep_last) state_nxt = S_RESP;
      end
      S_RESP:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.status = st_r;
    busy       = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        cmd.clear = 1'b1;
      end
      S_IDLE:     cmd.latch    = start;
      S_DECODE:   cmd.addr_clr = 1'b1;
      S_SCAN:     cmd.scan     = 1'b1;
      S_ALLOC_WR: cmd.alloc_wr = 1'b1;
      S_FREE_RD:  cmd.free_rd  = 1'b1;
      S_FREE_WR:  cmd.free_wr  = 1'b1;
      S_FORMAT:   cmd.sweep    = 1'b1;
      S_RESP:     cmd.respond  = 1'b1;
      default:    cmd          = '0;
    endcase
  end

endmodule

FILE: design/bffa_dp.sv
module bffa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bffa_pkg::cmd_t                cmd,
  output bffa_pkg::sts_t                sts,
  input  logic [1:0]                    in_func,
  input  logic                          in_pool,
  input  logic [bffa_pkg::CNT_W-1:0]    in_index,
  input  logic                          cfg_we,
  input  logic [bffa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bffa_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output logic [bffa_pkg::CNT_W-1:0]    out_number,
  output logic [1:0]                    out_status,
  output logic [bffa_pkg::CNT_W-1:0]    out_free_left
);
  import bffa_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES     = '1;
  localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAP_BITS);
  localparam logic [WADDR_W-1:0]   LAST_W   = WADDR_W'(WORDS - 1);

  // Bits of word w lying below a bit count: full words under hi, partial at hi.
  function automatic logic [WORD_BITS-1:0] below_mask(
    input logic [WADDR_W-1:0] w,
    input logic [CNT_W-1:0]   lim
  );
    logic [HI_W-1:0]  hi;
    logic [BIT_W-1:0] lo;
    logic [HI_W-1:0]  wx;
    hi = lim[CNT_W-1:BIT_W];
    lo = lim[BIT_W-1:0];
    wx = HI_W'(w);
    if (wx < hi) begin
      below_mask = ONES;
    end else if (wx == hi) begin
      below_mask = ~(ONES << lo);
    end else begin
      below_mask = '0;
    end
  endfunction

  function automatic logic [CNT_W-1:0] limit(input logic [CNT_W-1:0] c);
    limit = (c > CNT_MAX) ? CNT_MAX : c;
  endfunction

  // configuration
  logic [CNT_W-1:0] block_count_r, inode_count_r, reserved_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= CNT_W'(1024);
      inode_count_r <= CNT_W'(128);
      reserved_r    <= CNT_W'(21);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_COUNT:     block_count_r <= cfg_wdata;
        CFG_INODE_COUNT:     inode_count_r <= cfg_wdata;
        CFG_RESERVED_BLOCKS: reserved_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] bc_lim, ic_lim, rb_lim;
  assign bc_lim = limit(block_count_r);
  assign ic_lim = limit(inode_count_r);
  assign rb_lim = limit(reserved_r);

  // request capture
  logic [1:0]       func_r;
  logic             pool_r;
  logic [CNT_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      pool_r <= in_pool;
      idx_r  <= in_index;
    end
  end

  // free counters
  logic [CNT_W-1:0] free_blk_r, free_blk_nxt;
  logic [CNT_W-1:0] free_ino_r, free_ino_nxt;
  logic [CNT_W-1:0] cnt_sel, count_sel;

  assign cnt_sel   = pool_r ? free_ino_r : free_blk_r;
  assign count_sel = pool_r ? ic_lim : bc_lim;

  // word counter for scan and sweep
  logic [WADDR_W-1:0] addr_r, addr_nxt;
  logic [WADDR_W-1:0] chk_w_r;
  logic               pvalid_r;

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.addr_clr) begin
      addr_nxt = '0;
    end else if (cmd.scan || cmd.sweep) begin
      addr_nxt = addr_r + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      pvalid_r <= 1'b0;
    end else begin
      addr_r   <= addr_nxt;
      pvalid_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    chk_w_r <= addr_r;
  end

  // bitmap memories
  logic [WORD_BITS-1:0] blk_rdata, ino_rdata, rdata;
  logic [WORD_BITS-1:0] wdata, wr_word;
  logic [WADDR_W-1:0]   ram_addr;
  logic                 we_blk, we_ino;

  assign rdata = pool_r ? ino_rdata : blk_rdata;

  // first-free search on the word read last cycle
  logic [WORD_BITS-1:0] free_bits, onehot;
  logic [BIT_W-1:0]     enc;

  assign free_bits = ~rdata & below_mask(chk_w_r, count_sel);
  assign onehot    = free_bits & (~free_bits + WORD_BITS'(1));

  always_comb begin
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) enc = enc | BIT_W'(i);
    end
  end

  logic [WORD_BITS-1:0] hold_word_r, hold_onehot_r;
  logic [WADDR_W-1:0]   hold_w_r;
  logic [CNT_W-1:0]     hold_num_r, number_r;

  always_ff @(posedge clk) begin
    if (cmd.scan && sts.found) begin
      hold_word_r   <= rdata;
      hold_onehot_r <= onehot;
      hold_w_r      <= chk_w_r;
      hold_num_r    <= CNT_W'({chk_w_r, enc}) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      number_r <= '0;
    end else if (cmd.alloc_wr) begin
      number_r <= hold_num_r;
    end
  end

  // bit to free
  logic [BITNUM_W-1:0]  fbit;
  logic [WADDR_W-1:0]   free_w;
  logic [WORD_BITS-1:0] free_onehot;

  assign fbit        = BITNUM_W'(idx_r - CNT_W'(1));
  assign free_w      = fbit[BITNUM_W-1:BIT_W];
  assign free_onehot = WORD_BITS'(1) << fbit[BIT_W-1:0];

  always_comb begin
    if (cmd.free_rd || cmd.free_wr) begin
      ram_addr = free_w;
    end else if (cmd.alloc_wr) begin
      ram_addr = hold_w_r;
    end else begin
      ram_addr = addr_r;
    end
  end

  assign wr_word = cmd.alloc_wr ? (hold_word_r | hold_onehot_r) : (rdata & ~free_onehot);

  logic [WORD_BITS-1:0] fmt_blk_word, fmt_ino_word;
  assign fmt_blk_word = cmd.clear ? '0 : below_mask(addr_r, rb_lim);
  assign fmt_ino_word = (!cmd.clear && addr_r == '0) ? WORD_BITS'(1) : '0;

  assign we_blk = cmd.sweep || ((cmd.alloc_wr || cmd.free_wr) && !pool_r);
  assign we_ino = cmd.sweep || ((cmd.alloc_wr || cmd.free_wr) && pool_r);
  assign wdata  = wr_word;

  bffa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_blk_ram (
    .clk   (clk),
    .we    (we_blk),
    .addr  (ram_addr),
    .wdata (cmd.sweep ? fmt_blk_word : wdata),
    .rdata (blk_rdata)
  );

  bffa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ino_ram (
    .clk   (clk),
    .we    (we_ino),
    .addr  (ram_addr),
    .wdata (cmd.sweep ? fmt_ino_word : wdata),
    .rdata (ino_rdata)
  );

  // counter updates
  logic sweep_last;
  assign sweep_last = cmd.sweep && (addr_r == LAST_W);

  always_comb begin
    free_blk_nxt = free_blk_r;
    free_ino_nxt = free_ino_r;
    if (sweep_last && !cmd.clear) begin
      free_blk_nxt = (bc_lim != '0) ? bc_lim - CNT_W'(1) : '0;
      free_ino_nxt = (ic_lim != '0) ? ic_lim - CNT_W'(1) : '0;
    end else if (cmd.alloc_wr) begin
      if (pool_r) free_ino_nxt = free_ino_r - CNT_W'(1);
      else        free_blk_nxt = free_blk_r - CNT_W'(1);
    end else if (cmd.free_wr && (cnt_sel < count_sel)) begin
      if (pool_r) free_ino_nxt = free_ino_r + CNT_W'(1);
      else        free_blk_nxt = free_blk_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_blk_r <= '0;
      free_ino_r <= '0;
    end else begin
      free_blk_r <= free_blk_nxt;
      free_ino_r <= free_ino_nxt;
    end
  end

  // status to controller
  always_comb begin
    sts.func       = func_r;
    sts.cnt_zero   = (cnt_sel == '0);
    sts.idx_bad    = (idx_r == '0) || (idx_r >= count_sel);
    sts.found      = pvalid_r && (|free_bits);
    sts.last_word  = pvalid_r && ((HI_W'(chk_w_r) >= count_sel[CNT_W-1:BIT_W]) ||
                                  (chk_w_r == LAST_W));
    sts.sweep_last = sweep_last;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_number    <= number_r;
      out_status    <= cmd.status;
      out_free_left <= cnt_sel;
    end
  end

endmodule

FILE: design/bffa_chk.sv
`include "bitmap_first_free_allocator_defines.svh"

module bffa_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [bffa_pkg::CNT_W-1:0] out_number,
  input logic [1:0]                 out_status
);
  import bffa_pkg::*;

  // an accepted request keeps the block busy until its result
  `BFFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // the result shows up once the block is free again
  `BFFA_ASSERT_NOW(a_result_idle, out_valid, !busy)

  // one result per request: never two strobes in a row
  `BFFA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

  // a refused request carries no number
  `BFFA_ASSERT_NOW(a_fail_no_number, out_valid && (out_status != ST_OK), out_number == '0)

endmodule

bind bitmap_first_free_allocator bffa_chk u_chk (.*);
